// ===== rtl/core/binary_to_ascii_dec_hex_unit_macros.svh =====
// Assertion macros for the binary to ASCII converter.
`ifndef BINARY_TO_ASCII_DEC_HEX_UNIT_MACROS_SVH
`define BINARY_TO_ASCII_DEC_HEX_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Property must hold at every clock edge out of reset.
`define B2A_CHECK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Expression must never be true out of reset.
`define B2A_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define B2A_CHECK(lbl, prop, msg)
`define B2A_NEVER(lbl, expr, msg)
`endif

`endif

// ===== rtl/core/b2a_pkg.sv =====
// Types, format codes and the digit table of the binary to ASCII converter.
package b2a_pkg;

    localparam int DIGITS    = 10;
    localparam int BCD_W     = 4 * DIGITS;
    localparam int VALUE_W   = 32;
    localparam int STEP_W    = 6;
    localparam int LEFT_W    = 4;

    localparam logic [2:0] TYPE_DEC8  = 3'd0;
    localparam logic [2:0] TYPE_DEC16 = 3'd1;
    localparam logic [2:0] TYPE_DEC32 = 3'd2;
    localparam logic [2:0] TYPE_HEX8  = 3'd3;
    localparam logic [2:0] TYPE_HEX16 = 3'd4;
    localparam logic [2:0] TYPE_HEX32 = 3'd5;

    localparam logic [7:0] HEX_CHARS [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
    };

    typedef struct packed {
        logic [2:0]  req_type;
        logic [31:0] value;
    } req_t;

    typedef struct packed {
        logic [7:0] char_code;
        logic       is_last;
    } res_t;

    // Start of a bit-serial binary to BCD conversion.
    typedef struct packed {
        logic                valid;
        logic [VALUE_W-1:0]  bits;   // left aligned, MSB shifts out first
        logic [STEP_W-1:0]   steps;
    } dab_load_t;

    // Start of a character run.
    typedef struct packed {
        logic               valid;
        logic [BCD_W-1:0]   digits;  // left aligned, first character on top
        logic [LEFT_W-1:0]  count;
        logic               skip;    // drop leading zeros
    } emit_load_t;

endpackage

// ===== rtl/core/b2a_dabble.sv =====
// Bit-serial binary to BCD converter, one input bit per cycle (shift and add 3).
module b2a_dabble (
    input  logic                           clk,
    input  logic                           rst_n,
    input  b2a_pkg::dab_load_t             load,
    output logic                           done,
    output logic [b2a_pkg::BCD_W-1:0]      bcd
);

    logic                              run_reg, run_next;
    logic                              done_reg, done_next;
    logic [b2a_pkg::STEP_W-1:0]        cnt_reg, cnt_next;
    logic [b2a_pkg::VALUE_W-1:0]       bin_reg, bin_next;
    logic [b2a_pkg::BCD_W-1:0]         bcd_reg, bcd_next;
    logic [b2a_pkg::BCD_W-1:0]         adj;

    // Add 3 to each digit of 5 or more before the shift.
    always_comb
    begin
        for (int i = 0; i < b2a_pkg::DIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] >= 4'd5)
            begin
                adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            end
            else
            begin
                adj[4*i +: 4] = bcd_reg[4*i +: 4];
            end
        end
    end

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        if (load.valid)
        begin
            run_next = 1'b1;
            cnt_next = load.steps;
            bin_next = load.bits;
            bcd_next = '0;
        end
        else if (run_reg)
        begin
            bcd_next = {adj[b2a_pkg::BCD_W-2:0], bin_reg[b2a_pkg::VALUE_W-1]};
            bin_next = {bin_reg[b2a_pkg::VALUE_W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == b2a_pkg::STEP_W'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign done = done_reg;
    assign bcd  = bcd_reg;

endmodule

// ===== rtl/core/b2a_emit.sv =====
// Character serializer: one digit per cycle from the top of a shift register.
module b2a_emit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  b2a_pkg::emit_load_t  load,
    output logic                 last_issue,
    output logic                 strobe,
    output b2a_pkg::res_t        result
);

    logic                              active_reg, active_next;
    logic                              skip_reg, skip_next;
    logic                              strobe_reg;
    logic [b2a_pkg::LEFT_W-1:0]        left_reg, left_next;
    logic [b2a_pkg::BCD_W-1:0]         sr_reg, sr_next;
    b2a_pkg::res_t                     result_reg;
    logic [3:0]                        top;
    logic                              drop;
    logic                              issue;

    assign top        = sr_reg[b2a_pkg::BCD_W-1 -: 4];
    assign drop       = active_reg && skip_reg && (top == 4'd0)
                        && (left_reg > b2a_pkg::LEFT_W'(1));
    assign issue      = active_reg && !drop;
    assign last_issue = issue && (left_reg == b2a_pkg::LEFT_W'(1));

    always_comb
    begin
        active_next = active_reg;
        skip_next   = skip_reg;
        left_next   = left_reg;
        sr_next     = sr_reg;
        if (load.valid)
        begin
            active_next = 1'b1;
            skip_next   = load.skip;
            left_next   = load.count;
            sr_next     = load.digits;
        end
        else if (active_reg)
        begin
            sr_next   = {sr_reg[b2a_pkg::BCD_W-5:0], 4'd0};
            left_next = left_reg - 1'b1;
            if (issue)
            begin
                skip_next = 1'b0;
            end
            if (last_issue)
            begin
                active_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            strobe_reg <= issue;
        end
    end

    always_ff @(posedge clk)
    begin
        skip_reg             <= skip_next;
        left_reg             <= left_next;
        sr_reg               <= sr_next;
        result_reg.char_code <= b2a_pkg::HEX_CHARS[top];
        result_reg.is_last   <= (left_reg == b2a_pkg::LEFT_W'(1));
    end

    assign strobe = strobe_reg;
    assign result = result_reg;

endmodule

// ===== rtl/core/binary_to_ascii_dec_hex_unit.sv =====
// Top level of the binary to ASCII decimal / hexadecimal converter.
//
// Give an item by raising start with req while busy is low; the item is
// taken at that clock edge. Its characters come out most significant first,
// one per cycle, each on result for exactly one cycle with strobe high, and
// the final one carries is_last. The receiver cannot stall the block, so take
// every strobe. Decimal items first run a bit-serial shift-and-add-3 loop,
// one input bit per cycle over 8, 16 or 32 bits, then the character shifter
// walks all ten BCD digits for dec16/dec32, one per cycle, dropping leading
// zeros silently; dec8 emits three digits. Hex items go straight to the
// character shifter. busy falls with the last strobe of an item, so the
// next item can be taken in the cycle its final character is shown.
// Format codes 6 and 7 are taken and give no characters.
`include "binary_to_ascii_dec_hex_unit_macros.svh"

module binary_to_ascii_dec_hex_unit (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  b2a_pkg::req_t  req,
    output logic           strobe,
    output b2a_pkg::res_t  result
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]                  state_reg, state_next;
    logic [2:0]                  type_reg, type_next;
    logic                        accept;
    logic                        dab_done;
    logic [b2a_pkg::BCD_W-1:0]   dab_bcd;
    logic                        last_issue;
    b2a_pkg::dab_load_t          dab_load;
    b2a_pkg::emit_load_t         emit_load;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    // Route an accepted item: decimal to the BCD loop, hex to the shifter.
    always_comb
    begin
        state_next       = state_reg;
        type_next        = type_reg;
        dab_load         = '0;
        emit_load        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    type_next = req.req_type;
                    case (req.req_type)
                        b2a_pkg::TYPE_DEC8:
                        begin
                            dab_load.valid = 1'b1;
                            dab_load.bits  = {req.value[7:0], 24'd0};
                            dab_load.steps = b2a_pkg::STEP_W'(8);
                            state_next     = ST_CONV;
                        end
                        b2a_pkg::TYPE_DEC16:
                        begin
                            dab_load.valid = 1'b1;
                            dab_load.bits  = {req.value[15:0], 16'd0};
                            dab_load.steps = b2a_pkg::STEP_W'(16);
                            state_next     = ST_CONV;
                        end
                        b2a_pkg::TYPE_DEC32:
                        begin
                            dab_load.valid = 1'b1;
                            dab_load.bits  = req.value;
                            dab_load.steps = b2a_pkg::STEP_W'(32);
                            state_next     = ST_CONV;
                        end
                        b2a_pkg::TYPE_HEX8:
                        begin
                            emit_load.valid  = 1'b1;
                            emit_load.digits = {req.value[7:0], 32'd0};
                            emit_load.count  = b2a_pkg::LEFT_W'(2);
                            state_next       = ST_EMIT;
                        end
                        b2a_pkg::TYPE_HEX16:
                        begin
                            emit_load.valid  = 1'b1;
                            emit_load.digits = {req.value[15:0], 24'd0};
                            emit_load.count  = b2a_pkg::LEFT_W'(4);
                            state_next       = ST_EMIT;
                        end
                        b2a_pkg::TYPE_HEX32:
                        begin
                            emit_load.valid  = 1'b1;
                            emit_load.digits = {req.value, 8'd0};
                            emit_load.count  = b2a_pkg::LEFT_W'(8);
                            state_next       = ST_EMIT;
                        end
                        default:
                        begin
                            // Drop unused format codes without output.
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_CONV:
            begin
                // Hand the finished BCD word to the shifter.
                if (dab_done)
                begin
                    emit_load.valid = 1'b1;
                    if (type_reg == b2a_pkg::TYPE_DEC8)
                    begin
                        emit_load.digits = {dab_bcd[11:0], 28'd0};
                        emit_load.count  = b2a_pkg::LEFT_W'(3);
                        emit_load.skip   = 1'b0;
                    end
                    else
                    begin
                        emit_load.digits = dab_bcd;
                        emit_load.count  = b2a_pkg::LEFT_W'(b2a_pkg::DIGITS);
                        emit_load.skip   = 1'b1;
                    end
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (last_issue)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Format code of the item at work; no reset needed.
    always_ff @(posedge clk)
    begin
        type_reg <= type_next;
    end

    b2a_dabble u_dabble (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (dab_load),
        .done  (dab_done),
        .bcd   (dab_bcd)
    );

    b2a_emit u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (emit_load),
        .last_issue (last_issue),
        .strobe     (strobe),
        .result     (result)
    );

    // A character only follows a cycle of work on an item.
    `B2A_CHECK(a_strobe_after_busy, strobe |-> $past(busy), "strobe without an item at work")
    // The final character releases the block; earlier ones keep it busy.
    `B2A_CHECK(a_last_frees, (strobe && result.is_last) |-> !busy, "busy after last char")
    `B2A_CHECK(a_mid_busy, (strobe && !result.is_last) |-> busy, "idle before last char")
    // The BCD loop only finishes while the top level waits for it.
    `B2A_NEVER(a_done_in_state, dab_done && (state_reg != ST_CONV), "stray BCD done")

endmodule
